// ===== design/sspg_pkg.sv =====
// Shared types and codes for the stepper step pulse generator.
`default_nettype none
package sspg_pkg;

  // Input item command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_TIMED = 2'd1;
  localparam logic [1:0] CMD_CONT  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_REVERSE_MODE = 1'b0;
  localparam logic CFG_DEFAULT_DIR  = 1'b1;

  // One result item: the line levels after an input item.
  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic enable_n;
    logic running;
  } result_t;

  // Configuration write request from the port into the core.
  typedef struct packed {
    logic we;
    logic index;
    logic wdata;
  } cfg_wr_t;

endpackage
`default_nettype wire

// ===== design/stepper_step_pulse_generator.sv =====
// Top level of the stepper step pulse generator.
`default_nettype none
// Accepts an item (tick, timed start, continuous start or stop) per unstalled
// clock cycle and returns one result item per input item, holding the step,
// direction, enable and running levels after that item. The state update is
// a single pass of compare and increment logic on the COUNT_WIDTH counters,
// so the result enters the output buffer at the edge that accepts the item
// and is offered on the result channel from the next cycle. A two-entry
// output buffer lets input items keep flowing while one result waits; input
// is stalled only when both entries are held. Configuration writes are taken
// in every cycle (cfg_ready is always high) and must arrive while idle.
module stepper_step_pulse_generator #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_cmd,
  input  wire  [31:0] in_period_ticks,
  input  wire  [31:0] in_duration_ticks,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_step_level,
  output logic        out_dir_level,
  output logic        out_enable_n,
  output logic        out_running,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire         cfg_index,
  input  wire         cfg_wdata
);
  import sspg_pkg::*;

  logic    item_acc;
  logic    buf_full;
  logic    buf_pop;
  result_t res_nxt;
  result_t head;
  cfg_wr_t cfg_wr;

  // Handshakes.
  assign cfg_ready    = 1'b1;
  assign in_stall     = buf_full;
  assign item_acc     = in_valid && !buf_full;
  assign buf_pop      = out_valid && !out_stall;
  assign cfg_wr.we    = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.wdata = cfg_wdata;

  sspg_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_acc       (item_acc),
    .cmd            (in_cmd),
    .period_ticks   (in_period_ticks),
    .duration_ticks (in_duration_ticks),
    .cfg_wr         (cfg_wr),
    .res_nxt        (res_nxt)
  );

  sspg_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_acc),
    .push_data (res_nxt),
    .pop       (buf_pop),
    .full      (buf_full),
    .not_empty (out_valid),
    .head      (head)
  );

  // Result fields.
  assign out_step_level = head.step_level;
  assign out_dir_level  = head.dir_level;
  assign out_enable_n   = head.enable_n;
  assign out_running    = head.running;

endmodule
`default_nettype wire

// ===== design/sspg_core.sv =====
// Step pulse state and per-item update logic of the stepper pulse generator.
`default_nettype none
module sspg_core #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   item_acc,
  input  wire [1:0]             cmd,
  input  wire [31:0]            period_ticks,
  input  wire [31:0]            duration_ticks,
  input  sspg_pkg::cfg_wr_t     cfg_wr,
  output sspg_pkg::result_t     res_nxt
);
  import sspg_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  logic                   reverse_r, reverse_nxt;
  logic                   default_dir_r, default_dir_nxt;
  logic                   run_active_r, run_active_nxt;
  logic                   timed_r, timed_nxt;
  logic                   step_high_r, step_high_nxt;
  logic [COUNT_WIDTH-1:0] run_count_r, run_count_nxt;
  logic [COUNT_WIDTH-1:0] run_limit_r, run_limit_nxt;
  logic [COUNT_WIDTH-1:0] period_count_r, period_count_nxt;
  logic [COUNT_WIDTH-1:0] period_limit_r, period_limit_nxt;
  logic [COUNT_WIDTH-1:0] half_limit_r, half_limit_nxt;
  logic                   dir_mem_r, dir_mem_nxt;
  logic                   dir_line_r, dir_line_nxt;
  logic                   enable_n_r, enable_n_nxt;

  logic [COUNT_WIDTH-1:0] period_clamp;
  logic [COUNT_WIDTH-1:0] duration_clamp;
  logic [COUNT_WIDTH-1:0] pc_base;

  // Saturate the 32-bit operands into the count range.
  generate
    if (COUNT_WIDTH > 32) begin : g_wide
      assign period_clamp   = {{(COUNT_WIDTH-32){1'b0}}, period_ticks};
      assign duration_clamp = {{(COUNT_WIDTH-32){1'b0}}, duration_ticks};
    end else if (COUNT_WIDTH == 32) begin : g_equal
      assign period_clamp   = period_ticks;
      assign duration_clamp = duration_ticks;
    end else begin : g_narrow
      assign period_clamp   = (|period_ticks[31:COUNT_WIDTH]) ? CNT_MAX
                                                              : period_ticks[COUNT_WIDTH-1:0];
      assign duration_clamp = (|duration_ticks[31:COUNT_WIDTH]) ? CNT_MAX
                                                                : duration_ticks[COUNT_WIDTH-1:0];
    end
  endgenerate

  // The period count restarts when the step line rises again.
  assign pc_base = (!step_high_r && (period_count_r >= period_limit_r)) ? '0 : period_count_r;

  // Next state for one item, or for one configuration write.
  always_comb begin
    reverse_nxt      = reverse_r;
    default_dir_nxt  = default_dir_r;
    run_active_nxt   = run_active_r;
    timed_nxt        = timed_r;
    step_high_nxt    = step_high_r;
    run_count_nxt    = run_count_r;
    run_limit_nxt    = run_limit_r;
    period_count_nxt = period_count_r;
    period_limit_nxt = period_limit_r;
    half_limit_nxt   = half_limit_r;
    dir_mem_nxt      = dir_mem_r;
    dir_line_nxt     = dir_line_r;
    enable_n_nxt     = enable_n_r;

    if (item_acc) begin
      case (cmd) inside
        CMD_TIMED, CMD_CONT: begin
          timed_nxt        = (cmd == CMD_TIMED);
          run_limit_nxt    = (cmd == CMD_TIMED) ? duration_clamp : CNT_ONE;
          run_active_nxt   = 1'b1;
          run_count_nxt    = '0;
          period_count_nxt = '0;
          period_limit_nxt = period_clamp;
          half_limit_nxt   = period_clamp >> 1;
          enable_n_nxt     = 1'b0;
          step_high_nxt    = 1'b1;
          if (reverse_r) begin
            dir_mem_nxt  = ~dir_mem_r;
            dir_line_nxt = ~dir_mem_r;
          end
        end
        CMD_STOP: begin
          timed_nxt      = 1'b0;
          run_active_nxt = 1'b0;
          enable_n_nxt   = 1'b1;
          dir_line_nxt   = 1'b0;
        end
        default: begin
          if (run_active_r) begin
            if (run_count_r < run_limit_r) begin
              if (step_high_r && (period_count_r >= half_limit_r)) begin
                step_high_nxt = 1'b0;
              end else if (!step_high_r && (period_count_r >= period_limit_r)) begin
                step_high_nxt = 1'b1;
              end
              period_count_nxt = (pc_base == CNT_MAX) ? CNT_MAX : pc_base + CNT_ONE;
              if (timed_r) begin
                run_count_nxt = (run_count_r == CNT_MAX) ? CNT_MAX : run_count_r + CNT_ONE;
              end
            end else begin
              run_active_nxt = 1'b0;
              enable_n_nxt   = 1'b1;
              dir_line_nxt   = 1'b0;
            end
          end
        end
      endcase
    end

    // Configuration writes must arrive only while the block is idle; it does not enforce this.
    if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        CFG_REVERSE_MODE: begin
          reverse_nxt = cfg_wr.wdata;
          dir_mem_nxt = default_dir_r;
        end
        CFG_DEFAULT_DIR: begin
          default_dir_nxt = cfg_wr.wdata;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reverse_r      <= 1'b0;
      default_dir_r  <= 1'b0;
      run_active_r   <= 1'b0;
      timed_r        <= 1'b0;
      step_high_r    <= 1'b0;
      run_count_r    <= '0;
      run_limit_r    <= '0;
      period_count_r <= '0;
      period_limit_r <= '0;
      half_limit_r   <= '0;
      dir_mem_r      <= 1'b0;
      dir_line_r     <= 1'b0;
      enable_n_r     <= 1'b1;
    end else begin
      reverse_r      <= reverse_nxt;
      default_dir_r  <= default_dir_nxt;
      run_active_r   <= run_active_nxt;
      timed_r        <= timed_nxt;
      step_high_r    <= step_high_nxt;
      run_count_r    <= run_count_nxt;
      run_limit_r    <= run_limit_nxt;
      period_count_r <= period_count_nxt;
      period_limit_r <= period_limit_nxt;
      half_limit_r   <= half_limit_nxt;
      dir_mem_r      <= dir_mem_nxt;
      dir_line_r     <= dir_line_nxt;
      enable_n_r     <= enable_n_nxt;
    end
  end

  // Levels after the item, captured by the output buffer.
  assign res_nxt.step_level = run_active_nxt & step_high_nxt;
  assign res_nxt.dir_level  = dir_line_nxt;
  assign res_nxt.enable_n   = enable_n_nxt;
  assign res_nxt.running    = run_active_nxt;

`ifndef ASSERT_OFF
  // The driver is enabled exactly while a run is active.
  a_enable_tracks_run: assert property (@(posedge clk) disable iff (!rst_n)
    enable_n_r == !run_active_r)
    else $error("enable line disagrees with run state");

  // The direction line is cleared whenever no run is active.
  a_dir_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    !run_active_r |-> !dir_line_r)
    else $error("direction line high while idle");

  // A continuous run never advances its run count.
  a_cont_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (run_active_r && !timed_r) |-> (run_count_r == '0 && run_limit_r == CNT_ONE))
    else $error("continuous run count moved");

  // A tick while idle leaves the run state alone.
  a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (item_acc && cmd == CMD_TICK && !run_active_r) |=> !run_active_r)
    else $error("idle tick started a run");
`endif

endmodule
`default_nettype wire

// ===== design/sspg_out_buf.sv =====
// Two-entry result buffer that decouples the result channel from the input channel.
`default_nettype none
module sspg_out_buf (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  sspg_pkg::result_t  push_data,
  input  wire                pop,
  output logic               full,
  output logic               not_empty,
  output sspg_pkg::result_t  head
);
  import sspg_pkg::*;

  result_t    slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // Result storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The fill count never passes the buffer depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("result buffer overfilled");

  // No item is pushed into a full buffer.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full result buffer");

  // No item is popped from an empty buffer.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty result buffer");

  // Pointers stay consistent with the fill count.
  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r ^ rd_ptr_r) == count_r[0])
    else $error("result buffer pointers out of step");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the stepper step pulse generator.
`timescale 1ns / 100ps
module tb_top;
  import sspg_pkg::*;

  localparam int CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 80;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] period;
    logic [31:0] duration;
  } cmd_item_t;

  // Clock, reset and block ports.
  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = CMD_TICK;
  logic [31:0] in_period_ticks = '0;
  logic [31:0] in_duration_ticks = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_step_level;
  logic out_dir_level;
  logic out_enable_n;
  logic out_running;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_REVERSE_MODE;
  logic cfg_wdata = 1'b0;

  // Pending command items and expected line levels.
  cmd_item_t pending_cmds[$];
  result_t expected_levels[$];
  cmd_item_t next_cmd;

  // Idling controls, set between phases.
  bit idle_sender = 1'b1;
  bit idle_receiver = 1'b1;
  bit hold_req = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Bookkeeping.
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int timed_starts = 0;
  int cont_starts = 0;
  int stops = 0;
  int settings_used = 1;

  // Predictor state of the pulse generator and its configuration.
  logic pg_rev = 1'b0;
  logic pg_def_dir = 1'b0;
  logic pg_active = 1'b0;
  logic pg_timed = 1'b0;
  logic pg_step = 1'b0;
  logic [CNT_W-1:0] pg_run_cnt = '0;
  logic [CNT_W-1:0] pg_run_lim = '0;
  logic [CNT_W-1:0] pg_per_cnt = '0;
  logic [CNT_W-1:0] pg_per_lim = '0;
  logic [CNT_W-1:0] pg_half_lim = '0;
  logic pg_dir_mem = 1'b0;
  logic pg_dir = 1'b0;
  logic pg_en_n = 1'b1;

  stepper_step_pulse_generator i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_period_ticks   (in_period_ticks),
    .in_duration_ticks (in_duration_ticks),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_step_level    (out_step_level),
    .out_dir_level     (out_dir_level),
    .out_enable_n      (out_enable_n),
    .out_running       (out_running),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Drops the driver lines and ends the run.
  function automatic void drop_lines();
    pg_active = 1'b0;
    pg_en_n = 1'b1;
    pg_dir = 1'b0;
  endfunction

  // Starts a run; a 32-bit period always fits the count, so no clamping.
  function automatic void begin_run(logic [31:0] period);
    pg_active = 1'b1;
    pg_run_cnt = '0;
    pg_per_cnt = '0;
    pg_per_lim = period;
    pg_half_lim = pg_per_lim >> 1;
    pg_en_n = 1'b0;
    if (pg_rev) begin
      pg_dir_mem = ~pg_dir_mem;
      pg_dir = pg_dir_mem;
    end
    pg_step = 1'b1;
  endfunction

  // Advances the predictor by one command item and returns the line levels.
  function automatic result_t predict_levels(logic [1:0] cmd, logic [31:0] period,
                                             logic [31:0] duration);
    result_t lv;
    case (cmd)
      CMD_TIMED: begin
        pg_timed = 1'b1;
        pg_run_lim = duration;
        begin_run(period);
      end
      CMD_CONT: begin
        pg_timed = 1'b0;
        pg_run_lim = CNT_W'(1);
        begin_run(period);
      end
      CMD_STOP: begin
        pg_timed = 1'b0;
        drop_lines();
      end
      default: begin
        if (pg_active) begin
          if (pg_run_cnt < pg_run_lim) begin
            if (pg_step && pg_per_cnt >= pg_half_lim) begin
              pg_step = 1'b0;
            end else if (!pg_step && pg_per_cnt >= pg_per_lim) begin
              pg_step = 1'b1;
              pg_per_cnt = '0;
            end
            if (pg_per_cnt != CNT_MAX) pg_per_cnt = pg_per_cnt + 1'b1;
            if (pg_timed && pg_run_cnt != CNT_MAX) pg_run_cnt = pg_run_cnt + 1'b1;
          end else begin
            drop_lines();
          end
        end
      end
    endcase
    lv.step_level = pg_active & pg_step;
    lv.dir_level = pg_dir;
    lv.enable_n = pg_en_n;
    lv.running = pg_active;
    return lv;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_level(string name, logic want, logic got);
    if (got !== want)
      report_error($sformatf("%s is %b, expected %b (result %0d)", name, got, want,
                             results_seen));
  endtask

  task automatic queue_item(logic [1:0] cmd, logic [31:0] period, logic [31:0] duration);
    cmd_item_t it;
    it.cmd = cmd;
    it.period = period;
    it.duration = duration;
    pending_cmds.push_back(it);
  endtask

  // Mostly small counts so steps and run ends show up; now and then a full-range one.
  function automatic logic [31:0] pick_count(int top);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return $urandom_range(0, top);
  endfunction

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_reg(logic idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_REVERSE_MODE) begin
      pg_rev = val;
      pg_dir_mem = pg_def_dir;
    end else begin
      pg_def_dir = val;
    end
  endtask

  // Lets the sender pause until every expected item has come back.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_levels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed runs with random content, the rest random noise.
  task automatic add_random_items(int count);
    int added;
    int ticks;
    logic timed_start;
    logic [31:0] per;
    logic [31:0] dur;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) < 7) begin
        timed_start = 1'($urandom_range(0, 1));
        per = pick_count(12);
        dur = pick_count(36);
        queue_item(timed_start ? CMD_TIMED : CMD_CONT, per, dur);
        if (timed_start && dur < 37) ticks = $urandom_range(0, dur + 3);
        else ticks = $urandom_range(0, 40);
        repeat (ticks) queue_item(CMD_TICK, $urandom, $urandom);
        if ($urandom_range(0, 2) == 0) queue_item(CMD_STOP, $urandom, $urandom);
        added += ticks + 2;
      end else begin
        queue_item(2'($urandom_range(0, 3)), $urandom, $urandom);
        added++;
      end
    end
  endtask

  // Driver: offers pending items, predicts each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_levels.push_back(predict_levels(in_cmd, in_period_ticks,
                                                 in_duration_ticks));
        items_sent++;
        if (in_cmd == CMD_TIMED) timed_starts++;
        if (in_cmd == CMD_CONT) cont_starts++;
        if (in_cmd == CMD_STOP) stops++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          next_cmd = pending_cmds.pop_front();
          in_valid <= 1'b1;
          in_cmd <= next_cmd.cmd;
          in_period_ticks <= next_cmd.period;
          in_duration_ticks <= next_cmd.duration;
          gap_left = (idle_sender && $urandom_range(0, 1)) ? $urandom_range(0, 16) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result item against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          report_error("result item arrived with no expectation waiting");
        end else begin
          result_t want;
          want = expected_levels.pop_front();
          check_level("step_level", want.step_level, out_step_level);
          check_level("dir_level", want.dir_level, out_dir_level);
          check_level("enable_n", want.enable_n, out_enable_n);
          check_level("running", want.running, out_running);
        end
        results_seen++;
        stall_left = (idle_receiver && $urandom_range(0, 1)) ? $urandom_range(0, 16) : 0;
      end
      if (hold_req) begin
        hold_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when nothing is accepted for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus sequence: directed corners, then random phases over several settings.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle tick and idle stop, then zero and one periods alternating every tick.
    queue_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(CMD_CONT, 32'd0, 32'd0);
    repeat (3) queue_item(CMD_TICK, 32'd0, 32'd0);
    queue_item(CMD_CONT, 32'd1, 32'd0);
    repeat (2) queue_item(CMD_TICK, 32'd0, 32'd0);
    // Zero duration ends on the first tick; then the widest period and duration.
    queue_item(CMD_TIMED, 32'd4, 32'd0);
    repeat (2) queue_item(CMD_TICK, 32'd0, 32'd0);
    queue_item(CMD_TIMED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (2) queue_item(CMD_TICK, 32'd0, 32'd0);
    // Restart while running, stop while running, tick after stop, stop again.
    queue_item(CMD_TIMED, 32'd5, 32'd8);
    repeat (6) queue_item(CMD_TICK, 32'd0, 32'd0);
    queue_item(CMD_STOP, 32'd0, 32'd0);
    queue_item(CMD_TICK, 32'd0, 32'd0);
    queue_item(CMD_STOP, 32'd0, 32'd0);
    wait_drained();

    // Reverse mode starting from direction one, both sides idling.
    write_reg(CFG_DEFAULT_DIR, 1'b1);
    write_reg(CFG_REVERSE_MODE, 1'b1);
    settings_used++;
    add_random_items(110);
    wait_drained();

    // No idling, and one long receiver hold so the input backs up.
    write_reg(CFG_DEFAULT_DIR, 1'b0);
    write_reg(CFG_REVERSE_MODE, 1'b1);
    settings_used++;
    idle_sender = 1'b0;
    idle_receiver = 1'b0;
    hold_req = 1'b1;
    add_random_items(110);
    wait_drained();

    // Fixed direction, sender idling only.
    write_reg(CFG_REVERSE_MODE, 1'b0);
    write_reg(CFG_DEFAULT_DIR, 1'b1);
    settings_used++;
    idle_sender = 1'b1;
    add_random_items(110);
    wait_drained();

    // Reverse mode reloaded from direction one, receiver idling only.
    write_reg(CFG_REVERSE_MODE, 1'b1);
    write_reg(CFG_DEFAULT_DIR, 1'b0);
    settings_used++;
    idle_sender = 1'b0;
    idle_receiver = 1'b1;
    add_random_items(110);
    wait_drained();

    repeat (8) @(posedge clk);
    if (expected_levels.size() != 0)
      report_error($sformatf("%0d expected result items never arrived",
                             expected_levels.size()));
    $display("Run covered %0d command items (%0d timed starts, %0d continuous starts, %0d stops)",
             items_sent, timed_starts, cont_starts, stops);
    $display("and %0d result items over %0d register settings, %0d mismatches.",
             results_seen, settings_used, errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
